FILE: hdl/insertion_sorter_defines.svh
// Assertion macros used by the insertion sorter datapath.
// No dependencies; the checks compile away when SYNTH is defined.
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define ISORT_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("insertion sorter check failed");
// The consequent must hold in the cycle after the antecedent.
`define ISORT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("insertion sorter check failed");
`else
`define ISORT_ASSERT_NOW(lbl, ck, rs, ante, cons)
`define ISORT_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

FILE: hdl/isort_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies; used by every module of the block.
package isort_pkg;

  localparam int CAPACITY_DEFAULT = 32;
  localparam int DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_set;
    logic                     overflow;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;
    logic shift;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_one;
  } status_t;

endpackage

FILE: hdl/insertion_sorter.sv
// Top level of the insertion sorter: controller plus cell-chain datapath.
// Uses isort_pkg, isort_ctrl and isort_datapath.
//
//   channel | direction | payload               | handshake
//   in      | input     | in_item  (in_item_t)  | in_valid / in_stall
//   out     | output    | out_item (out_item_t) | out_valid / out_stall
//
// Each input item is inserted by parallel compare along the chain.
// After the item marked last, the set drains one result per cycle from the head
// cell while out_stall is low. Input is stalled while a set drains; output
// stall holds the head cell as is. Reset clears the fill count, overflow flag
// and controller; no clearing pass.
module insertion_sorter #(
  parameter int CAPACITY = isort_pkg::CAPACITY_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  isort_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output isort_pkg::out_item_t out_item
);

  isort_pkg::cmd_t    cmd;
  isort_pkg::status_t status;

  isort_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_item.last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  isort_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .value  (in_item.value),
    .status (status),
    .result (out_item)
  );

endmodule

FILE: hdl/isort_datapath.sv
// Datapath of the insertion sorter: a chain of sorted cells with
// parallel compare, the fill count and the overflow flag. Uses isort_pkg.
`include "insertion_sorter_defines.svh"

module isort_datapath #(
  parameter int CAPACITY = isort_pkg::CAPACITY_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  isort_pkg::cmd_t                    cmd,
  input  logic signed [isort_pkg::DATA_W-1:0] value,
  output isort_pkg::status_t                 status,
  output isort_pkg::out_item_t               result
);

  localparam int FILL_W = $clog2(CAPACITY + 1);

  logic signed [isort_pkg::DATA_W-1:0] store [CAPACITY];
  logic [FILL_W-1:0]                   fill;
  logic                                ovf;
  logic                                full;
  logic [CAPACITY-1:0]                 ins;

  assign full = (fill == FILL_W'(CAPACITY));

  // A cell takes part in the insert when its value is greater than the new
  // one, or when it is the first free cell. The chain is sorted, so these
  // cells form one run that ends at the first free cell.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (FILL_W'(i) < fill) begin
        ins[i] = (store[i] > value);
      end else begin
        ins[i] = (FILL_W'(i) == fill);
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.insert && !full && ins[0]) begin
          store[0] <= value;
        end else if (cmd.shift) begin
          store[0] <= store[1];
        end
      end
    end else if (i == CAPACITY - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (cmd.insert && !full && ins[i]) begin
          store[i] <= ins[i-1] ? store[i-1] : value;
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.insert && !full && ins[i]) begin
          store[i] <= ins[i-1] ? store[i-1] : value;
        end else if (cmd.shift) begin
          store[i] <= store[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      ovf  <= 1'b0;
    end else if (cmd.insert) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        fill <= fill + FILL_W'(1);
      end
    end else if (cmd.shift) begin
      fill <= fill - FILL_W'(1);
      if (fill == FILL_W'(1)) begin
        ovf <= 1'b0;
      end
    end
  end

  assign status.last_one     = (fill == FILL_W'(1));
  assign result.sorted_value = store[0];
  assign result.end_of_set   = (fill == FILL_W'(1));
  assign result.overflow     = ovf;

  `ISORT_ASSERT_NOW(a_fill_range, clk, rst, 1'b1, fill <= FILL_W'(CAPACITY))
  `ISORT_ASSERT_NEXT(a_fill_inc, clk, rst, cmd.insert && !full, fill == $past(fill) + FILL_W'(1))
  `ISORT_ASSERT_NEXT(a_fill_dec, clk, rst, cmd.shift, fill == $past(fill) - FILL_W'(1))
  `ISORT_ASSERT_NOW(a_head_order, clk, rst, fill >= FILL_W'(2), store[0] <= store[1])

endmodule

FILE: hdl/isort_ctrl.sv
// Controller of the insertion sorter: load and drain phases.
// Uses isort_pkg; drives the datapath commands and both handshakes.
module isort_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  isort_pkg::status_t status,
  output isort_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_valid && in_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!out_stall && status.last_one) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall   = (state != ST_LOAD);
  assign out_valid  = (state == ST_DRAIN);
  assign cmd.insert = (state == ST_LOAD) && in_valid;
  // Each output transfer pops the head cell of the chain.
  assign cmd.shift  = (state == ST_DRAIN) && !out_stall;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for insertion_sorter: drives sets of signed values and
// checks every sorted result against an in-bench model of the sorter.
// Depends on isort_pkg and the insertion_sorter RTL.
module tb_top;

  localparam int CAP = isort_pkg::CAPACITY_DEFAULT;
  localparam logic signed [isort_pkg::DATA_W-1:0] MOST_NEG =
    {1'b1, {(isort_pkg::DATA_W-1){1'b0}}};
  localparam logic signed [isort_pkg::DATA_W-1:0] MOST_POS =
    {1'b0, {(isort_pkg::DATA_W-1){1'b1}}};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  isort_pkg::in_item_t  in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  isort_pkg::out_item_t out_item;

  // Model state: values of the open set in ascending order, and the drop flag.
  logic signed [isort_pkg::DATA_W-1:0] held_vals[$];
  bit                                  held_ovf;
  isort_pkg::out_item_t                sorted_due[$];

  bit quiet;
  int fail_count;
  int items_sent;

  insertion_sorter #(.CAPACITY(CAP)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  // A new value lands after every held value not greater than it; when the
  // store is full it is dropped. The item marked last flushes the whole set.
  function automatic void insert_and_flush(isort_pkg::in_item_t it);
    int                   pos;
    isort_pkg::out_item_t res;
    pos = 0;
    if (held_vals.size() >= CAP) begin
      held_ovf = 1'b1;
    end else begin
      while (pos < held_vals.size() && held_vals[pos] <= it.value) pos++;
      held_vals.insert(pos, it.value);
    end
    if (it.last) begin
      foreach (held_vals[k]) begin
        res.sorted_value = held_vals[k];
        res.end_of_set   = (k == held_vals.size() - 1);
        res.overflow     = held_ovf;
        sorted_due = {sorted_due, res};
      end
      held_vals.delete();
      held_ovf = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) insert_and_flush(in_item);
  end

  always @(posedge clk) begin : check_results
    isort_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (sorted_due.size() == 0) begin
        $error("unexpected result: sorted_value %0d", out_item.sorted_value);
        fail_count++;
      end else begin
        want = sorted_due.pop_front();
        if (out_item.sorted_value !== want.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                 out_item.sorted_value);
          fail_count++;
        end
        if (out_item.end_of_set !== want.end_of_set) begin
          $error("end_of_set: expected %0b, got %0b", want.end_of_set,
                 out_item.end_of_set);
          fail_count++;
        end
        if (out_item.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_item.overflow);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 9);
  end

  // Holds valid and payload until the transfer happens; valid is only lowered
  // for a random gap, never in the step where it is raised again.
  task automatic send_item(input logic signed [isort_pkg::DATA_W-1:0] v, input logic l);
    isort_pkg::in_item_t it;
    it.value = v;
    it.last  = l;
    while (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  function automatic logic signed [isort_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return MOST_NEG;
      1: return MOST_POS;
      2, 3: return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_set(input int n);
    for (int k = 1; k <= n; k++) send_item(pick_value(), k == n);
  endtask

  task automatic test_extremes();
    send_item(MOST_POS, 1'b0);
    send_item(MOST_NEG, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(MOST_NEG, 1'b0);
    send_item(MOST_POS, 1'b0);
    send_item(32'sh5555_aaaa, 1'b0);
    send_item(32'sh2aaa_5555, 1'b1);
  endtask

  task automatic test_single_and_ties();
    // A set of one: the item marked last is the only value.
    send_item(MOST_NEG, 1'b1);
    send_item(MOST_POS, 1'b1);
    // Equal values mixed with a smaller and a larger one.
    send_item(3, 1'b0);
    send_item(3, 1'b0);
    send_item(-4, 1'b0);
    send_item(3, 1'b0);
    send_item(9, 1'b0);
    send_item(3, 1'b1);
  endtask

  task automatic test_full_store();
    // This stretch runs with no gaps on either side.
    quiet = 1'b1;
    // Exactly full with the last value: no drop.
    send_set(CAP);
    // Full before the last values: several drops, the last value among them,
    // and every result of the set flags it.
    send_set(CAP + 4);
    quiet = 1'b0;
  endtask

  task automatic test_random();
    int start;
    int n;
    start = items_sent;
    while (items_sent - start < 16) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(CAP - 3, CAP + 6)
                                      : $urandom_range(1, 10);
      send_set(n);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_single_and_ties();
    test_full_store();
    test_random();
    in_valid <= 1'b0;
    // One more edge so the final transfer has reached the model.
    @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (CAP + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hdl
hdl/isort_pkg.sv
hdl/isort_datapath.sv
hdl/isort_ctrl.sv
hdl/insertion_sorter.sv
tb/tb_top.sv
